/* design/rgb_led_effect_pwm_controller_defines.svh */
// Assertion macros for the RGB LED effect controller.
// They expect signals named clk and rst in the using scope.
`ifndef RGB_LED_EFFECT_PWM_CONTROLLER_DEFINES_SVH
`define RGB_LED_EFFECT_PWM_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

`define RLEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlep assertion failed: same-cycle implication");

`define RLEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlep assertion failed: next-cycle implication");

`else

`define RLEP_ASSERT_IMP(lbl, ante, cons)

`define RLEP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/rlep_pkg.sv */
package rlep_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_COLOUR = 2'd1;
  localparam logic [1:0] CMD_EFFECT = 2'd2;

  localparam logic [1:0] FX_OFF   = 2'd0;
  localparam logic [1:0] FX_SOLID = 2'd1;
  localparam logic [1:0] FX_BLINK = 2'd2;

  localparam logic [15:0] RELOAD_RESET = 16'hFFFF;
  localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

  // Values seen by the outputs after one request
  typedef struct packed {
    logic [23:0] colour;
    logic        lit;
    logic [1:0]  effect;
  } snap_t;

  // Load strobes of the two scaling stages
  typedef struct packed {
    logic ld_prod;
    logic ld_cmp;
  } pipe_en_t;

endpackage

/* design/rlep_state.sv */
module rlep_state (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [1:0]     cmd,
  input  logic [23:0]    colour,
  input  logic [1:0]     effect_req,
  input  logic [15:0]    blink_period,
  output rlep_pkg::snap_t snap_next
);
  import rlep_pkg::*;

  logic [23:0] stored_colour, stored_colour_next;
  logic [23:0] applied_colour, applied_colour_next;
  logic        on_flag, on_flag_next;
  logic [1:0]  effect_mode, effect_mode_next;
  logic [14:0] half_period, half_period_next;
  logic [15:0] elapsed_ms, elapsed_ms_next;
  logic [15:0] elapsed_inc;
  logic [1:0]  req_eff;

  always_comb begin
    stored_colour_next  = stored_colour;
    applied_colour_next = applied_colour;
    on_flag_next        = on_flag;
    effect_mode_next    = effect_mode;
    half_period_next    = half_period;
    elapsed_ms_next     = elapsed_ms;
    elapsed_inc = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 16'd1 : elapsed_ms;
    // solid while dark turns into off
    req_eff = (effect_req == FX_SOLID && !on_flag) ? FX_OFF : effect_req;
    unique case (cmd)
      CMD_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (effect_mode == FX_BLINK && elapsed_inc >= {1'b0, half_period}) begin
          elapsed_ms_next     = '0;
          applied_colour_next = on_flag ? 24'd0 : stored_colour;
          on_flag_next        = !on_flag;
        end
      end
      CMD_COLOUR: begin
        applied_colour_next = colour;
        on_flag_next        = (colour != 24'd0);
        if (colour != 24'd0) begin
          stored_colour_next = colour;
        end
      end
      CMD_EFFECT: begin
        if (effect_req == FX_OFF || effect_req == FX_SOLID || effect_req == FX_BLINK) begin
          applied_colour_next = (req_eff == FX_OFF) ? 24'd0 : stored_colour;
          effect_mode_next    = req_eff;
          elapsed_ms_next     = '0;
          half_period_next    = blink_period[15:1];
        end
      end
      default: begin
        // unknown command: hold everything
      end
    endcase
    snap_next.colour = applied_colour_next;
    snap_next.lit    = on_flag_next;
    snap_next.effect = effect_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_colour  <= '0;
      applied_colour <= '0;
      on_flag        <= 1'b0;
      effect_mode    <= FX_OFF;
      half_period    <= '0;
      elapsed_ms     <= '0;
    end else if (accept) begin
      stored_colour  <= stored_colour_next;
      applied_colour <= applied_colour_next;
      on_flag        <= on_flag_next;
      effect_mode    <= effect_mode_next;
      half_period    <= half_period_next;
      elapsed_ms     <= elapsed_ms_next;
    end
  end

endmodule

/* design/rlep_scale.sv */
module rlep_scale (
  input  logic               clk,
  input  rlep_pkg::pipe_en_t ctl,
  input  logic [15:0]        reload,
  input  logic [7:0]         level,
  output logic [15:0]        compare
);
  import rlep_pkg::*;

  logic [16:0] reload_p1;
  logic [24:0] prod, prod_next;
  logic [49:0] prod_w, recip;
  logic [16:0] quot;
  logic [15:0] compare_next;

  // (reload + 1) * level, at most 24 bits
  assign reload_p1 = {1'b0, reload} + 17'd1;
  assign prod_next = {8'd0, reload_p1} * {17'd0, level};

  // Divide by 255: multiply by 2^24 + 2^16 + 2^8 + 2, keep bits above 2^32.
  // Exact for every product this stage can see.
  assign prod_w = {25'd0, prod};
  assign recip  = (prod_w << 24) + (prod_w << 16) + (prod_w << 8) + (prod_w << 1);
  assign quot   = recip[48:32];
  // clamp underflow to zero
  assign compare_next = (quot == 17'd0) ? 16'd0 : 16'(quot - 17'd1);

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod <= prod_next;
    end
    if (ctl.ld_cmp) begin
      compare <= compare_next;
    end
  end

endmodule

/* design/rgb_led_effect_pwm_controller.sv */
// RGB LED effect controller: each request (millisecond tick, set colour or set effect)
// updates the LED state in the cycle it is accepted and yields one result holding the
// three PWM compare values, the on flag and the current effect. A request is taken every
// cycle while in_stall is low; its result is presented behind three register stages:
// the state stage, a product stage and a divide-by-255 stage. Each stage moves on
// its own, so bubbles close up, and a new request is taken while a finished result waits
// under out_stall as long as an earlier stage is free; in_stall rises only when all three
// stages hold a request and out_stall is high. Write pwm_reload only while nothing is in
// flight.
module rgb_led_effect_pwm_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [23:0] colour,
  input  logic [1:0]  effect_req,
  input  logic [15:0] blink_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red_compare,
  output logic [15:0] green_compare,
  output logic [15:0] blue_compare,
  output logic        lit,
  output logic [1:0]  effect_now
);
  import rlep_pkg::*;

`include "rgb_led_effect_pwm_controller_defines.svh"

  logic [15:0] pwm_reload;
  logic        accept;
  logic        v1, v2;
  logic        en1, en2, en3;
  snap_t       snap_next, snap;
  logic        lit2;
  logic [1:0]  effect2;
  pipe_en_t    ctl;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;
  assign ctl      = {en2 && v1, en3 && v2};

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_reload <= RELOAD_RESET;
    end else if (cfg_we) begin
      pwm_reload <= cfg_wdata;
    end
  end

  rlep_state u_state (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd),
    .colour       (colour),
    .effect_req   (effect_req),
    .blink_period (blink_period),
    .snap_next    (snap_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      snap <= snap_next;
    end
    if (ctl.ld_prod) begin
      lit2    <= snap.lit;
      effect2 <= snap.effect;
    end
    if (ctl.ld_cmp) begin
      lit        <= lit2;
      effect_now <= effect2;
    end
  end

  rlep_scale u_red (
    .clk     (clk),
    .ctl     (ctl),
    .reload  (pwm_reload),
    .level   (snap.colour[23:16]),
    .compare (red_compare)
  );

  rlep_scale u_green (
    .clk     (clk),
    .ctl     (ctl),
    .reload  (pwm_reload),
    .level   (snap.colour[15:8]),
    .compare (green_compare)
  );

  rlep_scale u_blue (
    .clk     (clk),
    .ctl     (ctl),
    .reload  (pwm_reload),
    .level   (snap.colour[7:0]),
    .compare (blue_compare)
  );

  // input held off only when every stage is occupied
  `RLEP_ASSERT_IMP(a_stall_full, in_stall, v1 && v2 && out_valid)
  // a black colour request leaves the LED dark
  `RLEP_ASSERT_NXT(a_black_dark, accept && cmd == CMD_COLOUR && colour == 24'd0,
                   v1 && !snap.lit && snap.colour == 24'd0)
  // an effect never reaches the outputs with the unused code
  `RLEP_ASSERT_IMP(a_effect_code, out_valid,
                   effect_now == FX_OFF || effect_now == FX_SOLID || effect_now == FX_BLINK)

endmodule
